/* rtl/vzs_pkg.sv */
// shared types and constants for the varint / zigzag / fixed serializer
package vzs_pkg;

    typedef enum logic [2:0] {
        CMD_VARUINT = 3'd0,
        CMD_SINT64  = 3'd1,
        CMD_SINT32  = 3'd2,
        CMD_FIXED64 = 3'd3,
        CMD_FIXED32 = 3'd4
    } vzs_cmd_t;

    typedef enum logic {
        ST_IDLE = 1'b0,
        ST_EMIT = 1'b1
    } vzs_state_t;

    localparam int unsigned VAL_W     = 64;
    localparam int unsigned HALF_W    = 32;
    localparam int unsigned GROUP_W   = 7;
    localparam int unsigned BYTE_W    = 8;
    localparam int unsigned CNT_W     = 3;
    localparam logic [CNT_W-1:0] FIXED64_LAST = 3'd7;
    localparam logic [CNT_W-1:0] FIXED32_LAST = 3'd3;

    // controller to datapath
    typedef struct packed {
        logic load;
        logic shift;
    } vzs_ctl_t;

    // datapath to controller
    typedef struct packed {
        logic last;
    } vzs_sts_t;

    function automatic logic cmd_known(input logic [2:0] c);
        return (c == CMD_VARUINT) || (c == CMD_SINT64) || (c == CMD_SINT32)
            || (c == CMD_FIXED64) || (c == CMD_FIXED32);
    endfunction

endpackage

/* rtl/varint_zigzag_fixed_serializer.sv */
// top level of the varint / zigzag / fixed wire-format serializer
// latency: first byte is valid the cycle after the request is taken
// throughput: one byte per cycle while out_ready is high; an item is 1 to 10 bytes,
//   and the next request is taken in the cycle its last byte is taken
// unknown commands are taken and dropped, producing no bytes
// reset (rst_n, async, active low) returns the controller to idle; no bytes pending
module varint_zigzag_fixed_serializer
    import vzs_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    input  logic [2:0]        cmd,
    input  logic [VAL_W-1:0]  value,
    output logic              out_valid,
    input  logic              out_ready,
    output logic [BYTE_W-1:0] out_byte,
    output logic              last
);

    // command and status between controller and datapath
    vzs_ctl_t ctl;
    vzs_sts_t sts;

    // controller: idle / emit state machine, owns both handshakes
    vzs_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .cmd       (cmd),
        .out_ready (out_ready),
        .sts       (sts),
        .in_ready  (in_ready),
        .out_valid (out_valid),
        .ctl       (ctl)
    );

    // datapath: zigzag transform on load (signed forms only), then shifts out 7-bit groups
    // (varint) or whole bytes (fixed) from a 64-bit register
    vzs_dp u_dp (
        .clk      (clk),
        .cmd      (cmd),
        .value    (value),
        .ctl      (ctl),
        .sts      (sts),
        .out_byte (out_byte),
        .last     (last)
    );

endmodule

/* rtl/vzs_dp.sv */
// datapath: operand transform, byte shift register and byte formatting
module vzs_dp
    import vzs_pkg::*;
(
    input  logic                clk,
    input  logic [2:0]          cmd,
    input  logic [VAL_W-1:0]    value,
    input  vzs_ctl_t            ctl,
    output vzs_sts_t            sts,
    output logic [BYTE_W-1:0]   out_byte,
    output logic                last
);

    logic [VAL_W-1:0]  val_reg, val_next;
    logic              fixed_reg, fixed_next;
    logic [CNT_W-1:0]  cnt_reg, cnt_next;

    logic [VAL_W-1:0]  load_val;
    logic              load_fixed;
    logic [CNT_W-1:0]  load_cnt;
    logic [HALF_W-1:0] w32;
    logic              rest_nz;

    assign w32 = value[HALF_W-1:0];

    always_comb
    begin
        load_val   = value;
        load_fixed = 1'b0;
        load_cnt   = FIXED64_LAST;
        unique case (cmd)
            CMD_VARUINT: load_val = value;
            CMD_SINT64:
            begin
                load_val = {value[VAL_W-2:0], 1'b0} ^ {VAL_W{value[VAL_W-1]}};
            end
            CMD_SINT32:
            begin
                load_val = {{(VAL_W-HALF_W){1'b0}},
                            ({w32[HALF_W-2:0], 1'b0} ^ {HALF_W{w32[HALF_W-1]}})};
            end
            CMD_FIXED64:
            begin
                load_fixed = 1'b1;
                load_cnt   = FIXED64_LAST;
            end
            CMD_FIXED32:
            begin
                load_val   = {{(VAL_W-HALF_W){1'b0}}, w32};
                load_fixed = 1'b1;
                load_cnt   = FIXED32_LAST;
            end
            default: load_val = value;
        endcase
    end

    // bits above the current varint group
    assign rest_nz = |val_reg[VAL_W-1:GROUP_W];

    always_comb
    begin
        if (fixed_reg)
        begin
            out_byte = val_reg[BYTE_W-1:0];
            last     = (cnt_reg == '0);
        end
        else
        begin
            out_byte = {rest_nz, val_reg[GROUP_W-1:0]};
            last     = !rest_nz;
        end
    end

    assign sts.last = last;

    always_comb
    begin
        val_next   = val_reg;
        fixed_next = fixed_reg;
        cnt_next   = cnt_reg;
        if (ctl.load)
        begin
            val_next   = load_val;
            fixed_next = load_fixed;
            cnt_next   = load_cnt;
        end
        else if (ctl.shift)
        begin
            if (fixed_reg)
            begin
                val_next = val_reg >> BYTE_W;
                cnt_next = cnt_reg - CNT_W'(1);
            end
            else
            begin
                val_next = val_reg >> GROUP_W;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        val_reg   <= val_next;
        fixed_reg <= fixed_next;
        cnt_reg   <= cnt_next;
    end

endmodule

/* rtl/vzs_ctrl.sv */
// controller: request handshakes and emit sequencing
module vzs_ctrl
    import vzs_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    input  logic [2:0] cmd,
    input  logic       out_ready,
    input  vzs_sts_t   sts,
    output logic       in_ready,
    output logic       out_valid,
    output vzs_ctl_t   ctl
);

    vzs_state_t state_reg, state_next;
    logic       in_fire;
    logic       out_fire;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        out_valid  = (state_reg == ST_EMIT);
        in_ready   = (state_reg == ST_IDLE) || (out_ready && sts.last);
        in_fire    = in_valid && in_ready;
        out_fire   = out_valid && out_ready;
        ctl.load   = in_fire && cmd_known(cmd);
        ctl.shift  = out_fire && !sts.last;
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (ctl.load)
                begin
                    state_next = ST_EMIT;
                end
            end
            ST_EMIT:
            begin
                if (out_fire && sts.last)
                begin
                    state_next = ctl.load ? ST_EMIT : ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

endmodule

/* rtl/vzs_check.sv */
// port-level checker for the serializer, bound to the top level
module vzs_check
    import vzs_pkg::*;
(
    input logic              clk,
    input logic              rst_n,
    input logic              in_valid,
    input logic              in_ready,
    input logic [2:0]        cmd,
    input logic [VAL_W-1:0]  value,
    input logic              out_valid,
    input logic              out_ready,
    input logic [BYTE_W-1:0] out_byte,
    input logic              last
);

    // a stalled byte holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(out_byte) && $stable(last))
        else $error("stalled output byte changed");

    // a new request is only taken while idle or as the last byte leaves
    a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready && out_valid |-> out_ready && last)
        else $error("request taken while bytes still pending");

    // an item does not end before its last byte
    a_continue: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_ready && !last |=> out_valid)
        else $error("encoding ended without last byte");

    // unknown commands give no bytes
    a_drop_unknown: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready && !out_valid && cmd != CMD_VARUINT && cmd != CMD_SINT64
        && cmd != CMD_SINT32 && cmd != CMD_FIXED64 && cmd != CMD_FIXED32
        |=> !out_valid)
        else $error("unknown command produced output");

endmodule

bind varint_zigzag_fixed_serializer vzs_check u_vzs_check (.*);

/* sim/tb_top.sv */
// self-checking testbench for the varint / zigzag / fixed wire-format serializer
module tb_top;
    import vzs_pkg::*;

    // quiet limit: cycles with no handshake on either side before giving up
    localparam int unsigned WATCHDOG_LIMIT = 1000;
    // cycles of settling after the last expected byte has been taken
    localparam int unsigned DRAIN_CYCLES   = 24;
    localparam int unsigned RANDOM_ITEMS   = 450;
    localparam int unsigned MAX_GAP        = 12;
    localparam int unsigned MAX_PRINTED    = 30;

    // one request as the driver presents it, with the idle cycles before it
    typedef struct {
        logic [2:0]       op;
        logic [VAL_W-1:0] operand;
        int unsigned      gap;
    } request_t;

    // one encoded byte as the block should hand it out
    typedef struct {
        logic [BYTE_W-1:0] data;
        logic              is_last;
    } wire_byte_t;

    logic              clk       = 1'b0;
    logic              rst_n     = 1'b0;
    logic              in_valid  = 1'b0;
    logic              in_ready;
    logic [2:0]        cmd       = 3'd0;
    logic [VAL_W-1:0]  value     = '0;
    logic              out_valid;
    logic              out_ready = 1'b0;
    logic [BYTE_W-1:0] out_byte;
    logic              last;

    request_t    pending_requests[$];
    wire_byte_t  wire_bytes_due[$];

    int unsigned requests_total    = 0;
    int unsigned requests_taken    = 0;
    int unsigned bytes_checked     = 0;
    int unsigned mismatches        = 0;
    int unsigned idle_cycles       = 0;
    int unsigned gap_count         = 0;
    int unsigned hold_count        = 0;
    int unsigned ready_wait        = 0;
    int unsigned taken_per_cmd[8];

    varint_zigzag_fixed_serializer uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .cmd       (cmd),
        .value     (value),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_byte  (out_byte),
        .last      (last)
    );

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    // ------------------------------------------------------------------
    // expected-byte computation
    // ------------------------------------------------------------------

    // base-128 groups, low group first; high bit says another byte follows
    function automatic void push_varint_bytes(input logic [VAL_W-1:0] v);
        logic [VAL_W-1:0] rest;
        wire_byte_t       wb;
        int               n;
        rest = v;
        n    = 0;
        do
        begin
            wb.data    = {1'b0, rest[GROUP_W-1:0]};
            rest       = rest >> GROUP_W;
            wb.is_last = (rest == '0);
            if (!wb.is_last)
                wb.data[BYTE_W-1] = 1'b1;
            wire_bytes_due.push_back(wb);
            n++;
        end
        while (rest != '0 && n < 10);
    endfunction

    // little-endian bytes, the top one flagged as last
    function automatic void push_fixed_bytes(input logic [VAL_W-1:0] v, input int nbytes);
        wire_byte_t wb;
        for (int k = 0; k < nbytes; k++)
        begin
            wb.data    = v[8*k +: 8];
            wb.is_last = (k == nbytes - 1);
            wire_bytes_due.push_back(wb);
        end
    endfunction

    // queue up every byte one request should produce
    function automatic void encode_wire_bytes(input logic [2:0] op, input logic [VAL_W-1:0] v);
        logic [VAL_W-1:0]  zz64;
        logic [HALF_W-1:0] low_word;
        logic [HALF_W-1:0] zz32;
        case (op)
            CMD_VARUINT:
                push_varint_bytes(v);
            CMD_SINT64:
            begin
                // zigzag: shift up, flip everything when negative
                zz64 = (v << 1) ^ {VAL_W{v[VAL_W-1]}};
                push_varint_bytes(zz64);
            end
            CMD_SINT32:
            begin
                // only the low word counts and the result stays 32 bits wide
                low_word = v[HALF_W-1:0];
                zz32     = (low_word << 1) ^ {HALF_W{low_word[HALF_W-1]}};
                push_varint_bytes({{(VAL_W-HALF_W){1'b0}}, zz32});
            end
            CMD_FIXED64:
                push_fixed_bytes(v, 8);
            CMD_FIXED32:
                push_fixed_bytes({{(VAL_W-HALF_W){1'b0}}, v[HALF_W-1:0]}, 4);
            default:
                ;   // unused codes are swallowed with no bytes
        endcase
    endfunction

    // ------------------------------------------------------------------
    // reporting
    // ------------------------------------------------------------------

    task automatic report_mismatch(input string what);
        mismatches++;
        if (mismatches <= MAX_PRINTED)
            $display("tb_top: mismatch at %0t: %s", $time, what);
    endtask

    task automatic add_request(input logic [2:0] op, input logic [VAL_W-1:0] v,
                               input int unsigned gap);
        request_t r;
        r.op      = op;
        r.operand = v;
        r.gap     = gap;
        pending_requests.push_back(r);
        requests_total++;
    endtask

    // random operand with a spread of magnitudes so every byte count turns up
    function automatic logic [VAL_W-1:0] pick_operand();
        logic [VAL_W-1:0] raw;
        raw = {$urandom, $urandom};
        case ($urandom_range(0, 3))
            0: return raw;
            1: return raw >> $urandom_range(0, VAL_W - 1);
            2: return ~(raw >> $urandom_range(0, VAL_W - 1));  // small negatives
            default: return VAL_W'($urandom_range(0, 300));
        endcase
    endfunction

    // ------------------------------------------------------------------
    // request driver
    // ------------------------------------------------------------------

    // a free slot is one where nothing is shown or the shown request is being taken;
    // the head request waits out its own gap before valid goes up
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid  <= 1'b0;
            gap_count <= 0;
        end
        else
        begin
            if (in_valid && in_ready)
            begin
                encode_wire_bytes(cmd, value);
                requests_taken++;
                taken_per_cmd[cmd]++;
            end
            if (!in_valid || in_ready)
            begin
                if (pending_requests.size() == 0)
                    in_valid <= 1'b0;
                else if (gap_count < pending_requests[0].gap)
                begin
                    in_valid  <= 1'b0;
                    gap_count <= gap_count + 1;
                end
                else
                begin
                    in_valid  <= 1'b1;
                    cmd       <= pending_requests[0].op;
                    value     <= pending_requests[0].operand;
                    gap_count <= 0;
                    void'(pending_requests.pop_front());
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // byte monitor and checker
    // ------------------------------------------------------------------

    // after each taken byte, draw how long ready stays low; stretches of
    // sixty bytes out of every hundred eighty run with no stall at all
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_ready  <= 1'b0;
            hold_count <= 0;
        end
        else if (out_valid && out_ready)
        begin
            if (wire_bytes_due.size() == 0)
                report_mismatch($sformatf("byte 0x%02h with none expected", out_byte));
            else
            begin
                if (out_byte !== wire_bytes_due[0].data)
                    report_mismatch($sformatf("out_byte 0x%02h, expected 0x%02h",
                                              out_byte, wire_bytes_due[0].data));
                if (last !== wire_bytes_due[0].is_last)
                    report_mismatch($sformatf("last %b, expected %b",
                                              last, wire_bytes_due[0].is_last));
                void'(wire_bytes_due.pop_front());
            end
            bytes_checked++;
            ready_wait = ((bytes_checked / 60) % 3 == 1) ? 0 : $urandom_range(0, MAX_GAP);
            if (ready_wait == 0)
                out_ready <= 1'b1;
            else
            begin
                out_ready  <= 1'b0;
                hold_count <= ready_wait;
            end
        end
        else if (!out_ready)
        begin
            if (hold_count <= 1)
            begin
                out_ready  <= 1'b1;
                hold_count <= 0;
            end
            else
                hold_count <= hold_count - 1;
        end
    end

    // ------------------------------------------------------------------
    // watchdog
    // ------------------------------------------------------------------

    always @(posedge clk)
    begin
        if ((in_valid && in_ready) || (out_valid && out_ready))
            idle_cycles <= 0;
        else if (idle_cycles >= WATCHDOG_LIMIT)
        begin
            $display("tb_top: no handshake for %0d cycles, %0d of %0d requests taken",
                     idle_cycles, requests_taken, requests_total);
            $display("tb_top: FAIL");
            $finish;
        end
        else
            idle_cycles <= idle_cycles + 1;
    end

    // ------------------------------------------------------------------
    // stimulus and end of run
    // ------------------------------------------------------------------

    initial
    begin
        logic [2:0]  op;
        int unsigned known_added;
        int unsigned gap;

        // directed: extremes of each encoding and the byte-count boundaries
        add_request(CMD_VARUINT, 64'h0, 0);
        add_request(CMD_VARUINT, 64'h7f, 0);
        add_request(CMD_VARUINT, 64'h80, $urandom_range(0, MAX_GAP));
        add_request(CMD_VARUINT, 64'h3fff, 0);
        add_request(CMD_VARUINT, 64'h4000, 1);
        add_request(CMD_VARUINT, 64'h8000_0000_0000_0000, 0);
        add_request(CMD_VARUINT, '1, 0);
        add_request(CMD_SINT64, 64'h0, $urandom_range(0, MAX_GAP));
        add_request(CMD_SINT64, '1, 0);                          // minus one
        add_request(CMD_SINT64, 64'h7fff_ffff_ffff_ffff, 0);     // most positive
        add_request(CMD_SINT64, 64'h8000_0000_0000_0000, 2);     // most negative
        add_request(CMD_SINT32, 64'h0, 0);
        add_request(CMD_SINT32, 64'h0000_0000_7fff_ffff, 0);
        add_request(CMD_SINT32, 64'h0000_0000_8000_0000, 0);
        add_request(CMD_SINT32, 64'hffff_ffff_ffff_ffff, 3);
        // upper word must not leak into the 32-bit forms
        add_request(CMD_SINT32, 64'h5a5a_a5a5_0000_0001, 0);
        add_request(CMD_FIXED64, 64'h0, 0);
        add_request(CMD_FIXED64, '1, 0);
        add_request(CMD_FIXED64, 64'h0123_4567_89ab_cdef, 0);
        add_request(CMD_FIXED32, 64'h0, 0);
        add_request(CMD_FIXED32, 64'hdead_beef_ffff_ffff, 0);
        add_request(CMD_FIXED32, 64'hffff_ffff_1234_5678, 0);
        // unused codes go in and nothing comes out
        add_request(3'd5, '1, 0);
        add_request(3'd6, 64'h0123_4567_89ab_cdef, 0);
        add_request(3'd7, 64'h0, 0);

        // random: mostly real encodings, a few unused codes as noise;
        // every third block of fifty goes back to back
        known_added = 0;
        for (int i = 0; known_added < RANDOM_ITEMS; i++)
        begin
            if ($urandom_range(0, 19) == 0)
                op = 3'($urandom_range(5, 7));
            else
            begin
                op = 3'($urandom_range(0, 4));
                known_added++;
            end
            gap = ((i / 50) % 3 == 2) ? 0 : $urandom_range(0, MAX_GAP);
            add_request(op, pick_operand(), gap);
        end

        repeat (6) @(posedge clk);
        rst_n <= 1'b1;

        while (requests_taken < requests_total)
            @(posedge clk);
        while (wire_bytes_due.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("tb_top: %0d requests taken (varuint %0d, sint64 %0d, sint32 %0d, fixed64 %0d,",
                 requests_taken, taken_per_cmd[CMD_VARUINT], taken_per_cmd[CMD_SINT64],
                 taken_per_cmd[CMD_SINT32], taken_per_cmd[CMD_FIXED64]);
        $display("tb_top:   fixed32 %0d, unused %0d), %0d bytes checked, %0d mismatches",
                 taken_per_cmd[CMD_FIXED32],
                 taken_per_cmd[5] + taken_per_cmd[6] + taken_per_cmd[7],
                 bytes_checked, mismatches);
        if (mismatches == 0)
            $display("tb_top: PASS");
        else
            $display("tb_top: FAIL");
        $finish;
    end

endmodule
